// ----- hw/rtl/harmonic_bending_energy_force_core_assert.svh -----
// Assertion macros shared by the bending energy and force core RTL.
`ifndef HARMONIC_BENDING_ENERGY_FORCE_CORE_ASSERT_SVH
`define HARMONIC_BENDING_ENERGY_FORCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HBEF_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbef check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HBEF_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbef check failed");
`else
`define HBEF_CHECK(label, ante, cons)
`define HBEF_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/hbef_pkg.sv -----
// Shared types and constants of the bending energy and force core.
package hbef_pkg;

	// Default number of fraction bits of the coordinate and force format.
	localparam int HBEF_FRAC_BITS_DEF = 16;

	// Operation codes of the shared divide and square-root unit.
	localparam logic HBEF_OP_DIV  = 1'b0;
	localparam logic HBEF_OP_SQRT = 1'b1;

	// Launch request for the shared unit.
	typedef struct packed {
		logic       start;
		logic       mode;
		logic [6:0] iters;
	} unit_ctl_t;

endpackage

// ----- hw/rtl/harmonic_bending_energy_force_core.sv -----
// Top level of the three-bead cosine bending energy and force core.
// Each request carries three bead positions in signed Q.FRAC_BITS and a stiffness
// k in unsigned Q.FRAC_BITS, and yields one result: the nine saturated force
// increments, the energy term k*(1 - cos) and the running energy total, which
// first_of_set restarts. Bond lengths and unit vectors come from a shared unit
// that retires one square-root or quotient bit per cycle; it performs two square
// roots, six unit-vector divisions and two force-magnitude divisions, and one
// registered 33x33 multiplier does the remaining products. A result enters the
// output register as soon as that register is free, and the next request can be
// accepted in the cycle in which that result becomes valid. Almost all of a
// request's time is spent in the shared unit; a request with a zero-length first
// bond goes from the normalization step straight to the done state. The core
// accepts one request at a time, but a new request may enter while the previous
// result still waits on the output register. A zero-length bond sets degenerate
// and zeroes the forces and the energy term.
module harmonic_bending_energy_force_core #(
	parameter int FRAC_BITS = hbef_pkg::HBEF_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] middle_x,
	input  logic signed [31:0] middle_y,
	input  logic signed [31:0] middle_z,
	input  logic signed [31:0] third_x,
	input  logic signed [31:0] third_y,
	input  logic signed [31:0] third_z,
	input  logic        [31:0] stiffness,
	input  logic               first_of_set,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_first_x,
	output logic signed [31:0] force_first_y,
	output logic signed [31:0] force_first_z,
	output logic signed [31:0] force_middle_x,
	output logic signed [31:0] force_middle_y,
	output logic signed [31:0] force_middle_z,
	output logic signed [31:0] force_third_x,
	output logic signed [31:0] force_third_y,
	output logic signed [31:0] force_third_z,
	output logic        [31:0] energy_term,
	output logic        [47:0] energy_total,
	output logic               degenerate
);

	localparam logic [4:0] ST_IDLE       = 5'd0;
	localparam logic [4:0] ST_DIFF       = 5'd1;
	localparam logic [4:0] ST_NORM       = 5'd2;
	localparam logic [4:0] ST_SQ_MUL     = 5'd3;
	localparam logic [4:0] ST_SQ_ACC     = 5'd4;
	localparam logic [4:0] ST_SQRT_GO    = 5'd5;
	localparam logic [4:0] ST_SQRT_WAIT  = 5'd6;
	localparam logic [4:0] ST_UDIV_GO    = 5'd7;
	localparam logic [4:0] ST_UDIV_WAIT  = 5'd8;
	localparam logic [4:0] ST_DOT_MUL    = 5'd9;
	localparam logic [4:0] ST_DOT_ACC    = 5'd10;
	localparam logic [4:0] ST_COS        = 5'd11;
	localparam logic [4:0] ST_TERM_MUL   = 5'd12;
	localparam logic [4:0] ST_TERM_ACC   = 5'd13;
	localparam logic [4:0] ST_GDIV_GO    = 5'd14;
	localparam logic [4:0] ST_GDIV_WAIT  = 5'd15;
	localparam logic [4:0] ST_F_A        = 5'd16;
	localparam logic [4:0] ST_F_B        = 5'd17;
	localparam logic [4:0] ST_F_C        = 5'd18;
	localparam logic [4:0] ST_F_D        = 5'd19;
	localparam logic [4:0] ST_F_E        = 5'd20;
	localparam logic [4:0] ST_DONE       = 5'd21;

	localparam logic signed [32:0] Q30_ONE  = 33'sd1073741824;
	localparam logic        [63:0] HALF30   = 64'd536870912;
	localparam logic        [6:0]  G_ITERS  = 7'(33 + FRAC_BITS);
	localparam logic        [6:0]  U_ITERS  = 7'd31;
	localparam logic        [47:0] SUM_MAX  = '1;

	// Round a product in Q.60 back to Q.30, half away from zero.
	function automatic logic signed [33:0] rnd30(input logic signed [65:0] x);
		logic [65:0] m;
		logic [65:0] r;
		m = x[65] ? $unsigned(-x) : $unsigned(x);
		r = (m + 66'(HALF30)) >> 30;
		rnd30 = x[65] ? -$signed({1'b0, r[32:0]}) : $signed({1'b0, r[32:0]});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
		if (v > 62'sd2147483647) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < -62'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic [4:0] state_q;
	logic [1:0] idx_q;
	logic       bond_q;
	logic       which_q;
	logic       degen_q;

	logic signed [31:0] p_q [9];
	logic        [31:0] k_q;
	logic               first_q;
	logic signed [32:0] b1_q [3];
	logic signed [32:0] b2_q [3];
	logic        [29:0] m_q [3];
	logic        [2:0]  neg_q;
	logic        [1:0]  s_q;
	logic        [61:0] sq_acc_q;
	logic        [30:0] n_q;
	logic        [33:0] len1_q;
	logic        [33:0] len2_q;
	logic signed [32:0] u1_q [3];
	logic signed [32:0] u2_q [3];
	logic signed [63:0] dot_q;
	logic signed [32:0] c_q;
	logic        [31:0] term_q;
	logic        [63:0] g1_q;
	logic        [63:0] g3_q;
	logic signed [32:0] v_q;
	logic        [33:0] lo_q;
	logic signed [60:0] f1_q [3];
	logic signed [60:0] f3_q [3];
	logic signed [65:0] prod_q;

	logic               out_valid_q;
	logic signed [31:0] of_q [9];
	logic        [31:0] oterm_q;
	logic        [47:0] sum_q;
	logic               odegen_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;

	hbef_pkg::unit_ctl_t unit_ctl;
	logic [63:0] unit_num;
	logic [34:0] unit_den;
	logic        unit_done;
	logic [63:0] unit_res;

	// Normalization of the current bond: magnitudes, largest one, and shift.
	logic signed [32:0] bsel [3];
	logic        [32:0] bmag [3];
	logic        [32:0] mx;
	logic        [1:0]  sh;

	logic        [63:0] g_sel;
	logic        [33:0] len_sel;
	logic        [31:0] vmag;
	logic signed [33:0] r_fb;
	logic signed [33:0] v_fb;
	logic signed [33:0] c_rnd;
	logic        [65:0] tr;
	logic        [59:0] fmag;
	logic        [48:0] sum_add;
	logic        [47:0] sum_next;
	logic signed [61:0] f2 [3];

	logic load_out;

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bsel[i] = bond_q ? b2_q[i] : b1_q[i];
			bmag[i] = bsel[i][32] ? 33'(-bsel[i]) : 33'(bsel[i]);
		end
		mx = bmag[0];
		if (bmag[1] > mx) begin
			mx = bmag[1];
		end
		if (bmag[2] > mx) begin
			mx = bmag[2];
		end
		if (mx < 33'd1073741824) begin
			sh = 2'd0;
		end else if ((mx >> 1) < 33'd1073741824) begin
			sh = 2'd1;
		end else if ((mx >> 2) < 33'd1073741824) begin
			sh = 2'd2;
		end else begin
			sh = 2'd3;
		end
	end

	assign g_sel   = which_q ? g3_q : g1_q;
	assign len_sel = which_q ? len2_q : len1_q;
	assign vmag    = v_q[32] ? 32'(-v_q) : 32'(v_q);
	assign r_fb    = rnd30(prod_q);
	assign v_fb    = which_q ? (34'(u1_q[idx_q]) - r_fb) : (r_fb - 34'(u2_q[idx_q]));
	assign c_rnd   = rnd30({{2{dot_q[63]}}, dot_q});
	assign tr      = 66'((prod_q[63:0] + HALF30) >> 30);
	assign fmag    = {prod_q[57:0], 2'b00} + 60'(lo_q);

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ_MUL: begin
				mul_a = $signed({3'b000, m_q[idx_q]});
				mul_b = $signed({3'b000, m_q[idx_q]});
			end
			ST_DOT_MUL: begin
				mul_a = u1_q[idx_q];
				mul_b = u2_q[idx_q];
			end
			ST_TERM_MUL: begin
				mul_a = $signed({1'b0, k_q});
				mul_b = Q30_ONE - c_q;
			end
			ST_F_A: begin
				mul_a = which_q ? u2_q[idx_q] : u1_q[idx_q];
				mul_b = c_q;
			end
			ST_F_C: begin
				mul_a = $signed({1'b0, g_sel[31:0]});
				mul_b = $signed({1'b0, vmag});
			end
			ST_F_D: begin
				mul_a = $signed({1'b0, g_sel[63:32]});
				mul_b = $signed({1'b0, vmag});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Requests to the shared divide and square-root unit.
	always_comb begin
		unit_ctl.start = 1'b0;
		unit_ctl.mode  = hbef_pkg::HBEF_OP_DIV;
		unit_ctl.iters = U_ITERS;
		unit_num       = '0;
		unit_den       = '0;
		case (state_q)
			ST_SQRT_GO: begin
				unit_ctl.start = 1'b1;
				unit_ctl.mode  = hbef_pkg::HBEF_OP_SQRT;
				unit_num       = {2'b00, sq_acc_q};
			end
			ST_UDIV_GO: begin
				// Unit component: round(m * 2^30 / n), half up.
				unit_ctl.start = 1'b1;
				unit_num       = ({34'd0, m_q[idx_q]} << 30) + 64'(n_q >> 1);
				unit_den       = {4'd0, n_q};
			end
			ST_GDIV_GO: begin
				// Force magnitude: round((k << FRAC_BITS) / L), half up.
				unit_ctl.start = 1'b1;
				unit_ctl.iters = G_ITERS;
				unit_num       = ({32'd0, k_q} << FRAC_BITS) + 64'(len_sel >> 1);
				unit_den       = {1'b0, len_sel};
			end
			default: begin
				unit_ctl.start = 1'b0;
			end
		endcase
	end

	hbef_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.num    (unit_num),
		.den    (unit_den),
		.done   (unit_done),
		.result (unit_res)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			bond_q  <= 1'b0;
			which_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					bond_q  <= 1'b0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					idx_q   <= '0;
					state_q <= (mx == '0) ? ST_DONE : ST_SQ_MUL;
				end
				ST_SQ_MUL: begin
					state_q <= ST_SQ_ACC;
				end
				ST_SQ_ACC: begin
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= ST_SQRT_GO;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT_WAIT;
				end
				ST_SQRT_WAIT: begin
					if (unit_done) begin
						state_q <= ST_UDIV_GO;
					end
				end
				ST_UDIV_GO: begin
					state_q <= ST_UDIV_WAIT;
				end
				ST_UDIV_WAIT: begin
					if (unit_done) begin
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							if (!bond_q) begin
								bond_q  <= 1'b1;
								state_q <= ST_NORM;
							end else begin
								state_q <= ST_DOT_MUL;
							end
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_UDIV_GO;
						end
					end
				end
				ST_DOT_MUL: begin
					state_q <= ST_DOT_ACC;
				end
				ST_DOT_ACC: begin
					if (idx_q == 2'd2) begin
						idx_q   <= '0;
						state_q <= ST_COS;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_DOT_MUL;
					end
				end
				ST_COS: begin
					state_q <= ST_TERM_MUL;
				end
				ST_TERM_MUL: begin
					state_q <= ST_TERM_ACC;
				end
				ST_TERM_ACC: begin
					which_q <= 1'b0;
					state_q <= ST_GDIV_GO;
				end
				ST_GDIV_GO: begin
					state_q <= ST_GDIV_WAIT;
				end
				ST_GDIV_WAIT: begin
					if (unit_done) begin
						which_q <= !which_q;
						idx_q   <= '0;
						state_q <= which_q ? ST_F_A : ST_GDIV_GO;
					end
				end
				ST_F_A: begin
					state_q <= ST_F_B;
				end
				ST_F_B: begin
					state_q <= ST_F_C;
				end
				ST_F_C: begin
					state_q <= ST_F_D;
				end
				ST_F_D: begin
					state_q <= ST_F_E;
				end
				ST_F_E: begin
					which_q <= !which_q;
					if (which_q && (idx_q == 2'd2)) begin
						state_q <= ST_DONE;
					end else begin
						if (which_q) begin
							idx_q <= idx_q + 2'd1;
						end
						state_q <= ST_F_A;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of one request.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q[0]  <= first_x;
				p_q[1]  <= first_y;
				p_q[2]  <= first_z;
				p_q[3]  <= middle_x;
				p_q[4]  <= middle_y;
				p_q[5]  <= middle_z;
				p_q[6]  <= third_x;
				p_q[7]  <= third_y;
				p_q[8]  <= third_z;
				k_q     <= stiffness;
				first_q <= first_of_set;
			end
			ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					b1_q[i] <= 33'(p_q[3 + i]) - 33'(p_q[i]);
					b2_q[i] <= 33'(p_q[6 + i]) - 33'(p_q[3 + i]);
				end
				degen_q <= 1'b0;
				term_q  <= '0;
			end
			ST_NORM: begin
				degen_q <= (mx == '0);
				s_q     <= sh;
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= 30'(bmag[i] >> sh);
					neg_q[i] <= bsel[i][32];
				end
				sq_acc_q <= '0;
			end
			ST_SQ_ACC: begin
				sq_acc_q <= sq_acc_q + prod_q[61:0];
			end
			ST_SQRT_WAIT: begin
				if (unit_done) begin
					n_q <= unit_res[30:0];
					if (bond_q) begin
						len2_q <= {3'b000, unit_res[30:0]} << s_q;
					end else begin
						len1_q <= {3'b000, unit_res[30:0]} << s_q;
					end
				end
			end
			ST_UDIV_WAIT: begin
				if (unit_done) begin
					if (bond_q) begin
						u2_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, unit_res[31:0]})
							: $signed({1'b0, unit_res[31:0]});
					end else begin
						u1_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, unit_res[31:0]})
							: $signed({1'b0, unit_res[31:0]});
					end
				end
				dot_q <= '0;
			end
			ST_DOT_ACC: begin
				dot_q <= dot_q + prod_q[63:0];
			end
			ST_COS: begin
				// Clamp cos to [-1, 1] so the energy term never goes negative.
				if (c_rnd > 34'(Q30_ONE)) begin
					c_q <= Q30_ONE;
				end else if (c_rnd < -34'(Q30_ONE)) begin
					c_q <= -Q30_ONE;
				end else begin
					c_q <= c_rnd[32:0];
				end
			end
			ST_TERM_ACC: begin
				term_q <= (tr[33:32] != 2'b00) ? 32'hFFFFFFFF : tr[31:0];
			end
			ST_GDIV_WAIT: begin
				if (unit_done) begin
					if (which_q) begin
						g3_q <= unit_res;
					end else begin
						g1_q <= unit_res;
					end
				end
			end
			ST_F_B: begin
				v_q <= v_fb[32:0];
			end
			ST_F_D: begin
				lo_q <= tr[33:0];
			end
			ST_F_E: begin
				if (which_q) begin
					f3_q[idx_q] <= v_q[32] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
				end else begin
					f1_q[idx_q] <= v_q[32] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
				end
			end
			default: begin
			end
		endcase
	end

	// Middle bead force and the running total.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			f2[i] = -(62'(f1_q[i]) + 62'(f3_q[i]));
		end
		sum_add  = {1'b0, sum_q} + 49'(term_q);
		if (first_q) begin
			sum_next = 48'(term_q);
		end else begin
			sum_next = sum_add[48] ? SUM_MAX : sum_add[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				sum_q       <= sum_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < 3; i++) begin
				of_q[i]     <= degen_q ? '0 : sat32(62'(f1_q[i]));
				of_q[3 + i] <= degen_q ? '0 : sat32(f2[i]);
				of_q[6 + i] <= degen_q ? '0 : sat32(62'(f3_q[i]));
			end
			oterm_q  <= term_q;
			odegen_q <= degen_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign force_first_x  = of_q[0];
	assign force_first_y  = of_q[1];
	assign force_first_z  = of_q[2];
	assign force_middle_x = of_q[3];
	assign force_middle_y = of_q[4];
	assign force_middle_z = of_q[5];
	assign force_third_x  = of_q[6];
	assign force_third_y  = of_q[7];
	assign force_third_z  = of_q[8];
	assign energy_term    = oterm_q;
	assign energy_total   = sum_q;
	assign degenerate     = odegen_q;

`include "harmonic_bending_energy_force_core_assert.svh"

	`HBEF_CHECK_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_DIFF)
	`HBEF_CHECK(a_result_from_done, $rose(out_valid), $past(state_q) == ST_DONE)
	`HBEF_CHECK(a_degen_no_energy, out_valid && degenerate, energy_term == 32'd0)
	`HBEF_CHECK(a_total_covers_term, out_valid, energy_total >= 48'(energy_term))

endmodule

// ----- hw/rtl/hbef_divsqrt.sv -----
// Shared iterative unit: restoring divider and digit-by-digit square root.
module hbef_divsqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  hbef_pkg::unit_ctl_t ctl,
	input  logic [63:0]         num,
	input  logic [34:0]         den,
	output logic                done,
	output logic [63:0]         result
);

	logic        busy_q;
	logic        done_q;
	logic        mode_q;
	logic [6:0]  cnt_q;
	logic [35:0] rem_q;
	logic [63:0] work_q;
	logic [63:0] quo_q;
	logic [34:0] den_q;

	logic [36:0] opa;
	logic [36:0] opb;
	logic [36:0] diff;
	logic        ge;

	// One compare and subtract serves both operations.
	always_comb begin
		if (mode_q == hbef_pkg::HBEF_OP_SQRT) begin
			opa = {rem_q[34:0], work_q[63:62]};
			opb = {quo_q[34:0], 2'b01};
		end else begin
			opa = {rem_q, work_q[63]};
			opb = {2'b00, den_q};
		end
		ge   = (opa >= opb);
		diff = opa - opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctl.mode == hbef_pkg::HBEF_OP_SQRT) ? 7'd32 : ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			den_q  <= den;
			quo_q  <= '0;
			if (ctl.mode == hbef_pkg::HBEF_OP_SQRT) begin
				rem_q  <= '0;
				work_q <= num;
			end else begin
				// Leading bits that cannot yield a quotient bit seed the remainder.
				rem_q  <= 36'(num >> ctl.iters);
				work_q <= num << (7'd64 - ctl.iters);
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[35:0] : opa[35:0];
			quo_q <= {quo_q[62:0], ge};
			if (mode_q == hbef_pkg::HBEF_OP_SQRT) begin
				work_q <= {work_q[61:0], 2'b00};
			end else begin
				work_q <= {work_q[62:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = quo_q;

`include "harmonic_bending_energy_force_core_assert.svh"

	`HBEF_CHECK(a_start_idle, ctl.start, !busy_q)
	`HBEF_CHECK(a_done_idle, done_q, !busy_q)
	`HBEF_CHECK_NEXT(a_done_after_last, busy_q && (cnt_q == 7'd1) && !ctl.start, done_q)

endmodule

// ----- test/tb_harmonic_bending_energy_force_core.sv -----
// Self-checking testbench for the three-bead cosine bending energy and force core.
`timescale 1ns / 1ps

module tb_harmonic_bending_energy_force_core;

	// The block runs one request at a time. The idle watchdog therefore has to cover
	// one full computation plus the longest output stall, with room to spare.
	localparam int FRAC_BITS     = hbef_pkg::HBEF_FRAC_BITS_DEF;
	localparam int IDLE_LIMIT    = 20000;
	localparam int DRAIN_CYCLES  = 600;
	localparam int RANDOM_ITEMS  = 1830;
	localparam longint unsigned Q30_ONE  = 64'd1 << 30;
	localparam longint unsigned TOTAL_MAX = (64'd1 << 48) - 1;

	// One request: nine coordinates (first, middle and third bead, x y z each),
	// the stiffness and the flag that restarts the energy total.
	typedef struct packed {
		logic [8:0][31:0] pos;
		logic      [31:0] k;
		logic             first;
	} bend_req_t;

	// One result: nine force components in the same order as the coordinates.
	typedef struct packed {
		logic [8:0][31:0] frc;
		logic      [31:0] term;
		logic      [47:0] total;
		logic             degen;
	} bend_result_t;

	// A directed row. Rows with typed set carry a hand-written expectation:
	// every force component is zero and the energy fields are as given.
	typedef struct {
		bend_req_t   req;
		bit          typed;
		logic [31:0] term;
		logic [47:0] total;
		logic        degen;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	bend_req_t cur_req = '0;
	bend_result_t dut_res;

	bend_result_t expected_results[$];
	directed_row_t directed_rows[$];
	longint unsigned energy_acc = 0;

	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int degenerate_seen = 0;
	int restarts_sent = 0;
	int idle_cycles = 0;
	bit draining = 1'b0;

	always #6 clk = ~clk;

	harmonic_bending_energy_force_core #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_x       (cur_req.pos[0]),
		.first_y       (cur_req.pos[1]),
		.first_z       (cur_req.pos[2]),
		.middle_x      (cur_req.pos[3]),
		.middle_y      (cur_req.pos[4]),
		.middle_z      (cur_req.pos[5]),
		.third_x       (cur_req.pos[6]),
		.third_y       (cur_req.pos[7]),
		.third_z       (cur_req.pos[8]),
		.stiffness     (cur_req.k),
		.first_of_set  (cur_req.first),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.force_first_x (dut_res.frc[0]),
		.force_first_y (dut_res.frc[1]),
		.force_first_z (dut_res.frc[2]),
		.force_middle_x(dut_res.frc[3]),
		.force_middle_y(dut_res.frc[4]),
		.force_middle_z(dut_res.frc[5]),
		.force_third_x (dut_res.frc[6]),
		.force_third_y (dut_res.frc[7]),
		.force_third_z (dut_res.frc[8]),
		.energy_term   (dut_res.term),
		.energy_total  (dut_res.total),
		.degenerate    (dut_res.degen)
	);

	// ------------------------------------------------------------------
	// Fixed-point bending predictor
	// ------------------------------------------------------------------

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Shift right with rounding half away from zero.
	function automatic longint round_shift(input longint v, input int sh);
		longint unsigned m;
		m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// Unit vector of a bond in Q2.30 and its length. The components are
	// pre-shifted so that their squares fit comfortably in 64 bits; the
	// length is scaled back up by the same shift. Returns 0 for a zero bond.
	function automatic bit unit_vector(input longint b[3], output longint u[3],
			output longint unsigned len);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sq;
		longint unsigned n;
		longint unsigned q;
		int s;
		mx = 0;
		sq = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(b[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		len = 0;
		for (int i = 0; i < 3; i++)
			u[i] = 0;
		if (mx == 0)
			return 1'b0;
		while ((mx >> s) >= (64'd1 << 30))
			s++;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= s;
			sq += m[i] * m[i];
		end
		n = int_sqrt(sq);
		if (n == 0)
			n = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (n >> 1)) / n;
			u[i] = (b[i] < 0) ? -longint'(q) : longint'(q);
		end
		len = n << s;
		return 1'b1;
	endfunction

	// Exact round(g * v / 2^30), half away from zero, split so that no
	// partial product overflows 64 bits.
	function automatic longint scale_by_q30(input longint unsigned g, input longint v);
		longint unsigned b;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned r;
		b = magnitude(v);
		hi = (g >> 32) * b;
		lo = ((g & 64'hFFFF_FFFF) * b + (64'd1 << 29)) >> 30;
		r = hi * 4 + lo;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] saturate_s32(input longint v);
		if (v > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Computes the result of one request and advances the energy total.
	function automatic bend_result_t predict_bending(input bend_req_t r);
		bend_result_t res;
		longint p[9];
		longint b1[3];
		longint b2[3];
		longint u1[3];
		longint u2[3];
		longint f1[3];
		longint f2[3];
		longint f3[3];
		longint unsigned len1;
		longint unsigned len2;
		longint unsigned term;
		longint unsigned kq;
		longint unsigned g1;
		longint unsigned g3;
		longint c;
		longint v1;
		longint v3;
		bit degen;
		kq = r.k;
		term = 0;
		len2 = 0;
		for (int i = 0; i < 9; i++)
			p[i] = $signed(r.pos[i]);
		for (int i = 0; i < 3; i++) begin
			b1[i] = p[3 + i] - p[i];
			b2[i] = p[6 + i] - p[3 + i];
			f1[i] = 0;
			f2[i] = 0;
			f3[i] = 0;
			u2[i] = 0;
		end
		degen = !unit_vector(b1, u1, len1);
		if (!degen)
			degen = !unit_vector(b2, u2, len2);
		if (!degen) begin
			c = 0;
			for (int i = 0; i < 3; i++)
				c += u1[i] * u2[i];
			c = round_shift(c, 30);
			// Straight and folded chains may round past +-1; clamp them.
			if (c > longint'(Q30_ONE))
				c = Q30_ONE;
			if (c < -longint'(Q30_ONE))
				c = -longint'(Q30_ONE);
			term = (kq * longint'(longint'(Q30_ONE) - c) + (64'd1 << 29)) >> 30;
			if (term > 64'hFFFF_FFFF)
				term = 64'hFFFF_FFFF;
			g1 = ((kq << FRAC_BITS) + (len1 >> 1)) / len1;
			g3 = ((kq << FRAC_BITS) + (len2 >> 1)) / len2;
			for (int i = 0; i < 3; i++) begin
				v1 = round_shift(u1[i] * c, 30) - u2[i];
				v3 = u1[i] - round_shift(u2[i] * c, 30);
				f1[i] = scale_by_q30(g1, v1);
				f3[i] = scale_by_q30(g3, v3);
				// The middle bead takes the reaction of the unsaturated outer forces.
				f2[i] = -(f1[i] + f3[i]);
			end
		end
		if (r.first) begin
			energy_acc = term;
		end else begin
			energy_acc = energy_acc + term;
			if (energy_acc > TOTAL_MAX)
				energy_acc = TOTAL_MAX;
		end
		for (int i = 0; i < 3; i++) begin
			res.frc[i]     = saturate_s32(f1[i]);
			res.frc[3 + i] = saturate_s32(f2[i]);
			res.frc[6 + i] = saturate_s32(f3[i]);
		end
		res.term = term[31:0];
		res.total = energy_acc[47:0];
		res.degen = degen;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic bend_req_t make_req(input int fx, fy, fz, mx, my, mz, tx, ty, tz,
			input logic [31:0] k, input logic first);
		bend_req_t r;
		r.pos = {tz, ty, tx, mz, my, mx, fz, fy, fx};
		r.k = k;
		r.first = first;
		return r;
	endfunction

	function automatic void add_row(input bend_req_t r, input bit typed,
			input logic [31:0] term, input logic [47:0] total, input logic degen);
		directed_row_t row;
		row.req = r;
		row.typed = typed;
		row.term = term;
		row.total = total;
		row.degen = degen;
		directed_rows = {directed_rows, row};
	endfunction

	// Coordinate for random requests. Most requests keep the beads a few
	// units apart so that the full bond and angle path is exercised; a share
	// use the whole 32-bit range to reach the saturation corners.
	function automatic logic [31:0] near_coord(input logic [31:0] base, input int spread);
		return base + $signed($urandom_range(2 * spread)) - spread;
	endfunction

	function automatic bend_req_t random_req();
		bend_req_t r;
		int sel;
		int spread;
		logic [31:0] base;
		sel = $urandom_range(99);
		spread = ($urandom_range(3) == 0) ? 32'h0000_0100 : 32'h0004_0000;
		base = $urandom;
		for (int i = 0; i < 3; i++) begin
			r.pos[i]     = near_coord(base, spread);
			r.pos[3 + i] = near_coord(base, spread);
			r.pos[6 + i] = near_coord(base, spread);
		end
		if (sel < 15) begin
			for (int i = 0; i < 9; i++)
				r.pos[i] = $urandom;
		end else if (sel < 20) begin
			// Zero-length first or second bond.
			if ($urandom_range(1))
				r.pos[2:0] = r.pos[5:3];
			else
				r.pos[8:6] = r.pos[5:3];
		end else if (sel < 26) begin
			// Nearly straight or nearly folded: third bead along +-b1.
			for (int i = 0; i < 3; i++)
				r.pos[6 + i] = ($urandom_range(1))
					? r.pos[3 + i] + (r.pos[3 + i] - r.pos[i]) + $urandom_range(2)
					: r.pos[i] + $urandom_range(2);
		end
		case ($urandom_range(5))
			0: r.k = $urandom;
			1: r.k = 32'hFFFF_FFFF - $urandom_range(3);
			2: r.k = $urandom_range(3);
			default: r.k = $urandom_range(32'h0040_0000);
		endcase
		r.first = ($urandom_range(7) == 0);
		return r;
	endfunction

	function automatic int random_gap();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// Presents one request, records its expected result when it is taken and
	// then idles for the given gap. With no gap the valid stays high and the
	// next request follows on the accepting edge itself.
	task automatic send_request(input bend_req_t r, input bit typed,
			input bend_result_t typed_res, input int gap);
		bend_result_t exp_res;
		cur_req <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		exp_res = predict_bending(r);
		if (typed)
			exp_res = typed_res;
		expected_results = {expected_results, exp_res};
		requests_sent++;
		if (r.first)
			restarts_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: stall pattern and checking
	// ------------------------------------------------------------------

	int stall_left = 0;
	bit stall_free = 1'b0;
	int phase_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			// Alternate between stretches with random stalls and stretches
			// where the result side always takes what it is offered.
			if (phase_left == 0) begin
				stall_free = ($urandom_range(3) == 0);
				phase_left = $urandom_range(200, 3000);
			end else begin
				phase_left--;
			end
			if (stall_free) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = random_gap();
				out_ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		bend_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding (total %0d)",
					$time, dut_res.total);
				mismatches++;
			end else begin
				exp_res = expected_results.pop_front();
				results_checked++;
				if (dut_res.degen)
					degenerate_seen++;
				for (int i = 0; i < 9; i++)
					if (dut_res.frc[i] !== exp_res.frc[i]) begin
						$display("%0t: force[%0d] expected %0d actual %0d", $time, i,
							$signed(exp_res.frc[i]), $signed(dut_res.frc[i]));
						mismatches++;
					end
				if (dut_res.term !== exp_res.term) begin
					$display("%0t: energy_term expected %0d actual %0d", $time,
						exp_res.term, dut_res.term);
					mismatches++;
				end
				if (dut_res.total !== exp_res.total) begin
					$display("%0t: energy_total expected %0d actual %0d", $time,
						exp_res.total, dut_res.total);
					mismatches++;
				end
				if (dut_res.degen !== exp_res.degen) begin
					$display("%0t: degenerate expected %0b actual %0b", $time,
						exp_res.degen, dut_res.degen);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on either side means
	// the block has hung.
	always @(posedge clk) begin
		if (arst_n && !draining) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		bend_result_t typed_res;
		bend_req_t r;
		int wait_count;

		// Directed rows. The typed rows are those whose result is obvious:
		// zero-length bonds, and exactly straight or folded chains whose
		// direction vectors cancel so that every force is zero.
		add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b0),
			1'b1, 32'd0, 48'd0, 1'b1);
		add_row(make_req(5, 6, 7, 9, 9, 9, 9, 9, 9, 32'hFFFF_FFFF, 1'b1),
			1'b1, 32'd0, 48'd0, 1'b1);
		add_row(make_req(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0,
			32'h0001_0000, 1'b1), 1'b1, 32'd0, 48'd0, 1'b0);
		add_row(make_req(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 1'b1),
			1'b1, 32'h0002_0000, 48'h0002_0000, 1'b0);
		add_row(make_req(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 1'b0),
			1'b1, 32'h0002_0000, 48'h0004_0000, 1'b0);
		// Folded chain with the largest stiffness saturates the energy term.
		add_row(make_req(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'hFFFF_FFFF, 1'b1),
			1'b1, 32'hFFFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
		// Right angle, small and large stiffness, and a zero stiffness.
		add_row(make_req(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0,
			32'h0001_0000, 1'b1), 1'b0, 0, 0, 0);
		add_row(make_req(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0,
			32'hFFFF_FFFF, 1'b0), 1'b0, 0, 0, 0);
		add_row(make_req(1, 2, 3, 32'h0003_0000, 32'h0001_8000, 32'hFFFF_0000,
			32'h0000_4000, 32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0), 1'b0, 0, 0, 0);
		// Shortest bonds: one least significant bit, forces saturate.
		add_row(make_req(0, 0, 0, 1, 0, 0, 1, 1, 0, 32'hFFFF_FFFF, 1'b0), 1'b0, 0, 0, 0);
		add_row(make_req(0, 0, 0, 0, 0, -1, 1, 1, -1, 32'h0001_0000, 1'b0), 1'b0, 0, 0, 0);
		// Coordinate extremes: the longest bonds need the pre-shift.
		add_row(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0),
			1'b0, 0, 0, 0);
		add_row(make_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0),
			1'b0, 0, 0, 0);
		add_row(make_req(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0100_0000, 1'b0), 1'b0, 0, 0, 0);
		add_row(make_req(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F,
			32'h1235_5678, 32'hEDCA_A987, 32'h0F0F_1F0F,
			32'h1233_0000, 32'hEDCB_0000, 32'h0F10_0000, 32'hAAAA_5555, 1'b0),
			1'b0, 0, 0, 0);
		// Degenerate second bond without a restart keeps the total.
		add_row(make_req(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0,
			32'h0001_0000, 1'b0), 1'b0, 0, 0, 0);

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed_res.frc = '0;
			typed_res.term = directed_rows[i].term;
			typed_res.total = directed_rows[i].total;
			typed_res.degen = directed_rows[i].degen;
			send_request(directed_rows[i].req, directed_rows[i].typed, typed_res,
				random_gap());
		end

		typed_res = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = random_req();
			send_request(r, 1'b0, typed_res, random_gap());
			// The sender holds off now and then until every result is back.
			if (n == RANDOM_ITEMS / 3 || n == (2 * RANDOM_ITEMS) / 3)
				wait_for_drain();
		end

		wait_for_drain();
		draining = 1'b1;
		wait_count = 0;
		while (wait_count < DRAIN_CYCLES) begin
			@(posedge clk);
			wait_count++;
		end

		$display("Sent %0d bending requests (%0d restarting the energy total), checked %0d",
			requests_sent, restarts_sent, results_checked);
		$display("results, %0d of them with a zero-length bond.", degenerate_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/hbef_pkg.sv
hw/rtl/hbef_divsqrt.sv
hw/rtl/harmonic_bending_energy_force_core.sv
test/tb_harmonic_bending_energy_force_core.sv
